@@ hw/rtl/sbt_pkg.sv @@
// sbt_pkg: types, codes and classification functions for the byte tokenizer.
// No dependencies.
package sbt_pkg;

    localparam int PW = 25;
    localparam int VW = 63;

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_NUM, M_NUMDOT, M_FRAC, M_STR, M_ESC, M_OP,
        M_LINE, M_BLOCK, M_BSTAR
    } mode_t;

    localparam logic [5:0] K_EOF = 6'd0;
    localparam logic [5:0] K_IDENT = 6'd1;
    localparam logic [5:0] K_NUM = 6'd2;
    localparam logic [5:0] K_STR = 6'd3;
    localparam logic [5:0] K_KW0 = 6'd4;
    localparam logic [5:0] K_DOT = 6'd32;
    localparam logic [5:0] K_ERR = 6'd57;

    typedef struct packed {
        logic [5:0]    kind;
        logic [PW-1:0] line;
        logic [PW-1:0] column;
        logic [PW-1:0] offset;
        logic [PW-1:0] length;
        logic [VW-1:0] value;
        logic          last;
    } token_t;

    // Up to three tokens per item, derived by the front end; cnt is 1 to 3.
    typedef struct packed {
        logic [1:0] cnt;
        token_t     t0;
        token_t     t1;
        token_t     t2;
    } entry_t;

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return b == 8'h20 || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic logic [5:0] single_kind(input logic [7:0] b);
        case (b)
            8'h28: return 6'd24;
            8'h29: return 6'd25;
            8'h7b: return 6'd26;
            8'h7d: return 6'd27;
            8'h5b: return 6'd28;
            8'h5d: return 6'd29;
            8'h3b: return 6'd30;
            8'h2c: return 6'd31;
            8'h2e: return 6'd32;
            8'h2d: return 6'd40;
            8'h25: return 6'd45;
            8'h5e: return 6'd50;
            default: return 6'd0;
        endcase
    endfunction

    function automatic logic [5:0] lone_kind(input logic [7:0] b);
        case (b)
            8'h3a: return 6'd34;
            8'h3d: return 6'd37;
            8'h2b: return 6'd39;
            8'h2a: return 6'd42;
            8'h2f: return 6'd44;
            8'h26: return 6'd47;
            8'h7c: return 6'd49;
            8'h21: return 6'd52;
            8'h3c: return 6'd54;
            8'h3e: return 6'd56;
            default: return 6'd0;
        endcase
    endfunction

    function automatic logic [5:0] pair_kind(input logic [7:0] p, input logic [7:0] b);
        if (p == 8'h3a && b == 8'h3a) return 6'd33;
        if (p == 8'h3d && b == 8'h3d) return 6'd35;
        if (p == 8'h3d && b == 8'h3e) return 6'd36;
        if (p == 8'h26 && b == 8'h26) return 6'd46;
        if (p == 8'h7c && b == 8'h7c) return 6'd48;
        if (b == 8'h3d) begin
            case (p)
                8'h2b: return 6'd38;
                8'h2a: return 6'd41;
                8'h2f: return 6'd43;
                8'h21: return 6'd51;
                8'h3c: return 6'd53;
                8'h3e: return 6'd55;
                default: return 6'd0;
            endcase
        end
        return 6'd0;
    endfunction

    localparam logic [63:0] KW_WORDS [20] = '{
        64'h6e66, 64'h74656c, 64'h74736e6f63, 64'h6669, 64'h65736c65,
        64'h656c696877, 64'h726f66, 64'h6e7275746572, 64'h6b61657262,
        64'h65756e69746e6f63, 64'h746375727473, 64'h6d756e65, 64'h6c706d69,
        64'h686374616d, 64'h74756d, 64'h656661736e75,
        64'h627570, 64'h76697270, 64'h657375, 64'h646f6d
    };
    localparam logic [3:0] KW_LENS [20] = '{
        4'd2, 4'd3, 4'd5, 4'd2, 4'd4, 4'd5, 4'd3, 4'd6, 4'd5, 4'd8,
        4'd6, 4'd4, 4'd4, 4'd5, 4'd3, 4'd6, 4'd3, 4'd4, 4'd3, 4'd3
    };

endpackage

@@ hw/rtl/sbt_front.sv @@
// sbt_front: per-byte scanner state machine; yields up to three tokens per item.
// Depends on sbt_pkg.
module sbt_front import sbt_pkg::*; #(
    parameter int MAX_BYTES = 16777216
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    input  logic       in_kind,
    input  logic [7:0] in_byte,
    output logic       in_ready,
    input  logic       q_full,
    output logic       q_push,
    output entry_t     q_data
);
    localparam logic [PW-1:0] CAP = PW'(MAX_BYTES);
    localparam logic [PW-1:0] LCAP = PW'(MAX_BYTES + 1);
    localparam logic [VW-1:0] VMAX = {VW{1'b1}};
    localparam logic [VW-1:0] VLIM = VMAX / 10;

    mode_t mode_reg, mode_next;
    logic [7:0] op_reg, op_next;
    logic [63:0] word_reg, word_next;
    logic [PW-1:0] cnt_reg, cnt_next, line_reg, line_next, col_reg, col_next;
    logic [PW-1:0] pos_reg, pos_next, sl_reg, sl_next, sc_reg, sc_next;
    logic [PW-1:0] sp_reg, sp_next;
    logic [VW-1:0] acc_reg, acc_next;
    logic sq_reg, sq_next;
    logic [5:0] wkind;

    assign in_ready = !q_full;
    wire fire = in_valid && in_ready;

    function automatic logic [PW-1:0] sadd(input logic [PW-1:0] a,
                                           input logic [PW-1:0] b,
                                           input logic [PW-1:0] c);
        logic [PW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, c}) ? c : s[PW-1:0];
    endfunction

    always_comb begin
        wkind = K_IDENT;
        for (int k = 19; k >= 0; k--) begin
            if (cnt_reg == PW'(KW_LENS[k]) && word_reg == KW_WORDS[k])
                wkind = K_KW0 + 6'(k);
        end
    end

    always_comb begin
        token_t cur, dot, nt;
        logic flush_f, idle_f, e_cur, e_dot, e_new;
        logic [VW+3:0] prod;
        logic [3:0] d;
        mode_next = mode_reg; op_next = op_reg; word_next = word_reg;
        cnt_next = cnt_reg; acc_next = acc_reg; line_next = line_reg;
        col_next = col_reg; pos_next = pos_reg; sl_next = sl_reg;
        sc_next = sc_reg; sp_next = sp_reg; sq_next = sq_reg;
        flush_f = 1'b0; idle_f = 1'b0; e_cur = 1'b0; e_dot = 1'b0; e_new = 1'b0;
        d = in_byte[3:0];
        prod = {4'b0, acc_reg} * 4'd10 + {{VW{1'b0}}, d};
        cur = '{K_IDENT, sl_reg, sc_reg, sp_reg, cnt_reg, '0, 1'b0};
        dot = '{K_DOT, sl_reg, sadd(sc_reg, cnt_reg, LCAP),
                sadd(sp_reg, cnt_reg, CAP), PW'(1), '0, 1'b0};
        nt = '{K_ERR, line_reg, col_reg, pos_reg, PW'(1), '0, 1'b0};
        if (in_kind) begin
            flush_f = 1'b1;
        end else begin
            unique case (mode_reg)
                M_IDENT: begin
                    if (is_alpha(in_byte) || is_digit(in_byte) || in_byte == 8'h5f) begin
                        if (cnt_reg < PW'(8))
                            word_next = word_reg | (64'(in_byte) << {cnt_reg[2:0], 3'b0});
                        cnt_next = sadd(cnt_reg, PW'(1), CAP);
                    end else begin flush_f = 1'b1; idle_f = 1'b1; end
                end
                M_NUM: begin
                    if (is_digit(in_byte)) begin
                        acc_next = (acc_reg > VLIM || prod[VW+3:VW] != 0) ? VMAX
                                   : prod[VW-1:0];
                        cnt_next = sadd(cnt_reg, PW'(1), CAP);
                    end else if (in_byte == 8'h2e) mode_next = M_NUMDOT;
                    else begin flush_f = 1'b1; idle_f = 1'b1; end
                end
                M_NUMDOT: begin
                    if (is_digit(in_byte)) begin
                        cnt_next = sadd(cnt_reg, PW'(2), CAP); mode_next = M_FRAC;
                    end else begin flush_f = 1'b1; idle_f = 1'b1; end
                end
                M_FRAC: begin
                    if (is_digit(in_byte)) cnt_next = sadd(cnt_reg, PW'(1), CAP);
                    else begin flush_f = 1'b1; idle_f = 1'b1; end
                end
                M_STR: begin
                    cnt_next = sadd(cnt_reg, PW'(1), CAP);
                    if (in_byte == (sq_reg ? 8'h27 : 8'h22)) begin
                        cur.kind = K_STR; cur.length = cnt_next; e_cur = 1'b1;
                        mode_next = M_IDLE;
                    end else if (in_byte == 8'h5c) mode_next = M_ESC;
                end
                M_ESC: begin
                    cnt_next = sadd(cnt_reg, PW'(1), CAP); mode_next = M_STR;
                end
                M_OP: begin
                    if (op_reg == 8'h2f && in_byte == 8'h2f) begin
                        mode_next = M_LINE; op_next = '0;
                    end else if (op_reg == 8'h2f && in_byte == 8'h2a) begin
                        mode_next = M_BLOCK; op_next = '0;
                    end else if (pair_kind(op_reg, in_byte) != 0) begin
                        cnt_next = sadd(cnt_reg, PW'(1), CAP);
                        cur.kind = pair_kind(op_reg, in_byte); cur.length = cnt_next;
                        e_cur = 1'b1; mode_next = M_IDLE; op_next = '0;
                    end else begin flush_f = 1'b1; idle_f = 1'b1; end
                end
                M_LINE: if (in_byte == 8'h0a) mode_next = M_IDLE;
                M_BLOCK: if (in_byte == 8'h2a) mode_next = M_BSTAR;
                M_BSTAR: begin
                    if (in_byte == 8'h2f) mode_next = M_IDLE;
                    else if (in_byte != 8'h2a) mode_next = M_BLOCK;
                end
                default: idle_f = 1'b1;
            endcase
        end
        if (flush_f) begin
            case (mode_reg)
                M_IDENT: begin cur.kind = wkind; e_cur = 1'b1; end
                M_NUM, M_FRAC: begin cur.kind = K_NUM; cur.value = acc_reg; e_cur = 1'b1; end
                M_NUMDOT: begin
                    cur.kind = K_NUM; cur.value = acc_reg; e_cur = 1'b1; e_dot = 1'b1;
                end
                M_STR, M_ESC: begin cur.kind = K_STR; e_cur = 1'b1; end
                M_OP: begin cur.kind = lone_kind(op_reg); e_cur = 1'b1; end
                default: ;
            endcase
            mode_next = M_IDLE; op_next = '0;
        end
        if (idle_f) begin
            mode_next = M_IDLE;
            if (!is_space(in_byte)) begin
                sl_next = line_reg; sc_next = col_reg; sp_next = pos_reg;
                cnt_next = PW'(1);
                if (is_alpha(in_byte) || in_byte == 8'h5f) begin
                    mode_next = M_IDENT; word_next = 64'(in_byte);
                end else if (is_digit(in_byte)) begin
                    mode_next = M_NUM; acc_next = VW'(d);
                end else if (in_byte == 8'h22 || in_byte == 8'h27) begin
                    mode_next = M_STR; sq_next = (in_byte == 8'h27);
                end else if (lone_kind(in_byte) != 0) begin
                    mode_next = M_OP; op_next = in_byte;
                end else begin
                    nt.kind = single_kind(in_byte) != 0 ? single_kind(in_byte) : K_ERR;
                    e_new = 1'b1;
                end
            end
        end
        if (in_kind) begin
            nt = '{K_EOF, line_reg, col_reg, pos_reg, '0, '0, 1'b0};
            e_new = 1'b1;
        end else begin
            pos_next = sadd(pos_reg, PW'(1), CAP);
            if (in_byte == 8'h0a) begin
                line_next = sadd(line_reg, PW'(1), LCAP); col_next = PW'(1);
            end else col_next = sadd(col_reg, PW'(1), LCAP);
        end
        // Pack flushed token, trailing dot and new token (or EOF) in order.
        q_data.cnt = 2'(e_cur) + 2'(e_dot) + 2'(e_new);
        q_data.t0 = e_cur ? cur : nt;
        q_data.t1 = e_dot ? dot : nt;
        q_data.t2 = nt;
        q_push = fire && (e_cur || e_new);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_IDLE; op_reg <= '0; word_reg <= '0; cnt_reg <= '0;
            acc_reg <= '0; line_reg <= PW'(1); col_reg <= PW'(1); pos_reg <= '0;
            sl_reg <= PW'(1); sc_reg <= PW'(1); sp_reg <= '0; sq_reg <= 1'b0;
        end else if (fire) begin
            mode_reg <= mode_next; op_reg <= op_next; word_reg <= word_next;
            cnt_reg <= cnt_next; acc_reg <= acc_next; line_reg <= line_next;
            col_reg <= col_next; pos_reg <= pos_next; sl_reg <= sl_next;
            sc_reg <= sc_next; sp_reg <= sp_next; sq_reg <= sq_next;
        end
    end
endmodule

@@ hw/rtl/sbt_queue.sv @@
// sbt_queue: small register FIFO of token entries between front and back.
// Depends on sbt_pkg.
module sbt_queue import sbt_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  entry_t wdata,
    output logic   full,
    input  logic   pop,
    output logic   empty,
    output entry_t rdata
);
    entry_t mem_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] n_reg;

    assign full = n_reg == 3'd4;
    assign empty = n_reg == 3'd0;
    assign rdata = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= wdata;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0; rp_reg <= '0; n_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + 2'd1;
            if (pop) rp_reg <= rp_reg + 2'd1;
            n_reg <= n_reg + 3'(push) - 3'(pop);
        end
    end
endmodule

@@ hw/rtl/sbt_back.sv @@
// sbt_back: drains queue entries and presents their tokens one per transaction.
// Depends on sbt_pkg.
module sbt_back import sbt_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   q_empty,
    input  entry_t q_data,
    output logic   q_pop,
    output logic   out_valid,
    input  logic   out_ready,
    output token_t out_tok
);
    logic [1:0] sel_reg, sel_next;
    always_comb begin
        out_valid = !q_empty;
        case (sel_reg)
            2'd0: out_tok = q_data.t0;
            2'd1: out_tok = q_data.t1;
            default: out_tok = q_data.t2;
        endcase
        out_tok.last = (sel_reg == q_data.cnt - 2'd1);
        q_pop = out_valid && out_ready && out_tok.last;
        sel_next = out_tok.last ? 2'd0 : sel_reg + 2'd1;
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) sel_reg <= 2'd0;
        else if (out_valid && out_ready) sel_reg <= sel_next;
    end
endmodule

@@ hw/rtl/source_byte_tokenizer_top.sv @@
// source_byte_tokenizer_top: byte-serial tokenizer, front scanner, queue, output.
// Depends on sbt_pkg, sbt_front, sbt_queue, sbt_back.
// Takes one byte or end-of-source transaction per cycle while the four-entry
// queue has room; the scanner pushes all tokens of the item as one queue
// entry, which is registered in the queue and offered once earlier entries
// have drained. The output moves one token per cycle while m_ready is high,
// so an item with two or three tokens (a number, its trailing dot and the
// next token or EOF) holds the output until all are taken; the input stalls
// only when the queue is full.
module source_byte_tokenizer_top import sbt_pkg::*; #(
    parameter int MAX_SOURCE_BYTES = 16777216
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic          s_kind,
    input  logic [7:0]    s_source_byte,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [5:0]    m_token_kind,
    output logic [PW-1:0] m_token_line,
    output logic [PW-1:0] m_token_column,
    output logic [PW-1:0] m_start_offset,
    output logic [PW-1:0] m_lexeme_length,
    output logic [VW-1:0] m_number_value,
    output logic          m_last_in_run
);
    logic q_full, q_push, q_pop, q_empty;
    entry_t q_w, q_r;
    token_t tok;

    sbt_front #(.MAX_BYTES(MAX_SOURCE_BYTES)) u_front (
        .aclk, .aresetn, .in_valid(s_valid), .in_kind(s_kind), .in_byte(s_source_byte),
        .in_ready(s_ready), .q_full, .q_push, .q_data(q_w));
    sbt_queue u_queue (.aclk, .aresetn, .push(q_push), .wdata(q_w), .full(q_full),
        .pop(q_pop), .empty(q_empty), .rdata(q_r));
    sbt_back u_back (.aclk, .aresetn, .q_empty, .q_data(q_r), .q_pop,
        .out_valid(m_valid), .out_ready(m_ready), .out_tok(tok));

    assign m_token_kind = tok.kind;
    assign m_token_line = tok.line;
    assign m_token_column = tok.column;
    assign m_start_offset = tok.offset;
    assign m_lexeme_length = tok.length;
    assign m_number_value = tok.value;
    assign m_last_in_run = tok.last;

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_full |-> !q_push) else $error("push into full queue");
    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> m_valid && m_ready && m_last_in_run) else $error("bad pop");
endmodule
